// ----- rtl/core/dqe_pkg.sv -----
// Package for the double-ended queue engine: sizes, request and status codes,
// controller command and datapath status types. No dependencies.
package dqe_pkg;

   localparam int DEPTH      = 1024;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_BACK  = 3'd1,
      REQ_POP_FRONT  = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_QUERY      = 3'd4,
      REQ_CLEAR      = 3'd5,
      REQ_REVERSE    = 3'd6,
      REQ_SORT       = 3'd7
   } req_code_type;

   typedef enum logic [1:0] {
      STS_OK         = 2'd0,
      STS_POP_EMPTY  = 2'd1,
      STS_PUSH_FULL  = 2'd2
   } status_code_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_EXEC,
      CMD_POP_DONE,
      CMD_RD_A,
      CMD_RD_B,
      CMD_WR_A,
      CMD_WR_B,
      CMD_ADV,
      CMD_PASS,
      CMD_RD_FRONT,
      CMD_RD_BACK,
      CMD_CAP_BACK,
      CMD_RESP
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      req_code_type req;
      logic         empty;
      logic         walk_more;
      logic         do_swap;
      logic         swapped;
      logic         rsp_busy;
   } dp_status_type;

   // stored word from the 32-bit request field
   function automatic logic [DATA_WIDTH-1:0] word_from_port(input logic [31:0] v);
      logic signed [63:0] w;
      w = 64'(signed'(v));
      return DATA_WIDTH'(w);
   endfunction

   // stored word sign-extended onto a 32-bit result field
   function automatic logic [31:0] word_to_port(input logic [DATA_WIDTH-1:0] v);
      logic signed [63:0] w;
      w = 64'(signed'(v));
      return w[31:0];
   endfunction

endpackage

// ----- rtl/core/dqe_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dqe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// ----- rtl/core/dqe_ctrl.sv -----
// Controller state machine of the deque engine.
// Depends on dqe_pkg; drives dqe_datapath by command, reads its status.
module dqe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dqe_pkg::dp_status_type dp_sts,
   output dqe_pkg::ctrl_cmd_type  cmd
);
   import dqe_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_WAIT,
      ST_WALK_CHK,
      ST_RD_B,
      ST_CMP,
      ST_WR_B,
      ST_RD_FRONT,
      ST_RD_BACK,
      ST_CAP_BACK,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = CMD_LOAD;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.op = CMD_EXEC;
            case (dp_sts.req)
               REQ_POP_FRONT, REQ_POP_BACK:
                  state_in = dp_sts.empty ? ST_RD_FRONT : ST_POP_WAIT;
               REQ_REVERSE, REQ_SORT:
                  state_in = ST_WALK_CHK;
               default:
                  state_in = ST_RD_FRONT;
            endcase
         end
         ST_POP_WAIT: begin
            cmd.op   = CMD_POP_DONE;
            state_in = ST_RD_FRONT;
         end
         ST_WALK_CHK: begin
            if (dp_sts.walk_more) begin
               cmd.op   = CMD_RD_A;
               state_in = ST_RD_B;
            end else if (dp_sts.req == REQ_SORT && dp_sts.swapped) begin
               cmd.op   = CMD_PASS;
            end else begin
               state_in = ST_RD_FRONT;
            end
         end
         ST_RD_B: begin
            cmd.op   = CMD_RD_B;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (dp_sts.do_swap) begin
               cmd.op   = CMD_WR_A;
               state_in = ST_WR_B;
            end else begin
               cmd.op   = CMD_ADV;
               state_in = ST_WALK_CHK;
            end
         end
         ST_WR_B: begin
            cmd.op   = CMD_WR_B;
            state_in = ST_WALK_CHK;
         end
         ST_RD_FRONT: begin
            cmd.op   = CMD_RD_FRONT;
            state_in = ST_RD_BACK;
         end
         ST_RD_BACK: begin
            cmd.op   = CMD_RD_BACK;
            state_in = ST_CAP_BACK;
         end
         ST_CAP_BACK: begin
            cmd.op   = CMD_CAP_BACK;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!dp_sts.rsp_busy) begin
               cmd.op   = CMD_RESP;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/dqe_datapath.sv -----
// Datapath of the deque engine: head and count, walk indices, result register.
// Depends on dqe_pkg and dqe_ram; commanded by dqe_ctrl.
module dqe_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  dqe_pkg::ctrl_cmd_type  cmd,
   output dqe_pkg::dp_status_type dp_sts,
   input  logic [2:0]             req_type,
   input  logic [31:0]            req_data_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_popped_value,
   output logic [31:0]            rsp_front_value,
   output logic [31:0]            rsp_back_value,
   output logic [10:0]            rsp_item_count,
   output logic                   rsp_is_empty,
   output logic [1:0]             rsp_status
);
   import dqe_pkg::*;

   function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] h,
                                              input logic [CNT_W-1:0] p);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(h) + (CNT_W+1)'(p);
      if (s >= (CNT_W+1)'(DEPTH)) begin
         s = s - (CNT_W+1)'(DEPTH);
      end
      return ADDR_W'(s);
   endfunction

   logic [ADDR_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      i_ff, i_in, j_ff, j_in;
   logic                  swapped_ff, swapped_in;
   req_code_type          req_ff, req_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [DATA_WIDTH-1:0] tmp_ff, tmp_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in, back_ff, back_in;
   logic [31:0]           popped_ff, popped_in;
   status_code_type       sts_ff, sts_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_pop_ff, rsp_pop_in, rsp_front_ff, rsp_front_in;
   logic [31:0]           rsp_back_ff, rsp_back_in;
   logic [10:0]           rsp_cnt_ff, rsp_cnt_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic [1:0]            rsp_sts_ff, rsp_sts_in;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;
   logic                  empty, full;
   logic [ADDR_W-1:0]     head_dec, head_inc;

   dqe_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff >= CNT_W'(DEPTH));
   assign head_dec = (head_ff == '0) ? ADDR_W'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == ADDR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   always_comb begin
      dp_sts.req       = req_ff;
      dp_sts.empty     = empty;
      dp_sts.walk_more = (req_ff == REQ_REVERSE) ? (cnt_ff > CNT_W'(1) && i_ff < j_ff)
                                                : (j_ff < cnt_ff);
      dp_sts.do_swap   = (req_ff == REQ_REVERSE) || ($signed(tmp_ff) > $signed(rd_data));
      dp_sts.swapped   = swapped_ff;
      dp_sts.rsp_busy  = rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      head_in = head_ff;   cnt_in = cnt_ff;
      i_in = i_ff;         j_in = j_ff;       swapped_in = swapped_ff;
      req_in = req_ff;     word_in = word_ff; tmp_in = tmp_ff;
      front_in = front_ff; back_in = back_ff;
      popped_in = popped_ff; sts_in = sts_ff;
      rsp_pop_in = rsp_pop_ff;   rsp_front_in = rsp_front_ff;
      rsp_back_in = rsp_back_ff; rsp_cnt_in = rsp_cnt_ff;
      rsp_empty_in = rsp_empty_ff; rsp_sts_in = rsp_sts_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en   = 1'b0;
      wr_addr = head_ff;
      wr_data = word_ff;
      rd_addr = head_ff;

      case (cmd.op)
         CMD_LOAD: begin
            req_in    = req_code_type'(req_type);
            word_in   = word_from_port(req_data_value);
            popped_in = '1;
            sts_in    = STS_OK;
         end
         CMD_EXEC: begin
            case (req_ff)
               REQ_PUSH_FRONT: begin
                  if (full) begin
                     sts_in = STS_PUSH_FULL;
                  end else begin
                     head_in = head_dec;
                     wr_en   = 1'b1;
                     wr_addr = head_dec;
                     cnt_in  = cnt_ff + 1'b1;
                  end
               end
               REQ_PUSH_BACK: begin
                  if (full) begin
                     sts_in = STS_PUSH_FULL;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = slot(head_ff, cnt_ff);
                     cnt_in  = cnt_ff + 1'b1;
                  end
               end
               REQ_POP_FRONT: begin
                  if (empty) sts_in = STS_POP_EMPTY;
               end
               REQ_POP_BACK: begin
                  if (empty) sts_in = STS_POP_EMPTY;
                  rd_addr = slot(head_ff, cnt_ff - 1'b1);
               end
               REQ_CLEAR: begin
                  head_in = '0;
                  cnt_in  = '0;
               end
               REQ_REVERSE: begin
                  i_in = '0;
                  j_in = cnt_ff - 1'b1;
               end
               REQ_SORT: begin
                  i_in       = '0;
                  j_in       = CNT_W'(1);
                  swapped_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         CMD_POP_DONE: begin
            popped_in = word_to_port(rd_data);
            cnt_in    = cnt_ff - 1'b1;
            if (req_ff == REQ_POP_FRONT) head_in = head_inc;
         end
         CMD_RD_A: begin
            rd_addr = slot(head_ff, i_ff);
         end
         CMD_RD_B: begin
            rd_addr = slot(head_ff, j_ff);
            tmp_in  = rd_data;
         end
         CMD_WR_A: begin
            wr_en   = 1'b1;
            wr_addr = slot(head_ff, i_ff);
            wr_data = rd_data;
         end
         CMD_WR_B, CMD_ADV: begin
            if (cmd.op == CMD_WR_B) begin
               wr_en      = 1'b1;
               wr_addr    = slot(head_ff, j_ff);
               wr_data    = tmp_ff;
               swapped_in = 1'b1;
            end
            i_in = i_ff + 1'b1;
            j_in = (req_ff == REQ_REVERSE) ? j_ff - 1'b1 : j_ff + 1'b1;
         end
         CMD_PASS: begin
            i_in       = '0;
            j_in       = CNT_W'(1);
            swapped_in = 1'b0;
         end
         CMD_RD_FRONT: begin
            rd_addr = head_ff;
         end
         CMD_RD_BACK: begin
            rd_addr  = slot(head_ff, cnt_ff - 1'b1);
            front_in = rd_data;
         end
         CMD_CAP_BACK: begin
            back_in = rd_data;
         end
         CMD_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_pop_in   = popped_ff;
            rsp_front_in = empty ? '1 : word_to_port(front_ff);
            rsp_back_in  = empty ? '1 : word_to_port(back_ff);
            rsp_cnt_in   = 11'(cnt_ff);
            rsp_empty_in = empty;
            rsp_sts_in   = sts_ff;
         end
         default: begin
         end
      endcase
      // a pop on the front reads at the head
      if (cmd.op == CMD_EXEC && req_ff == REQ_POP_FRONT) rd_addr = head_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff <= i_in;          j_ff <= j_in;          swapped_ff <= swapped_in;
      req_ff <= req_in;      word_ff <= word_in;    tmp_ff <= tmp_in;
      front_ff <= front_in;  back_ff <= back_in;
      popped_ff <= popped_in; sts_ff <= sts_in;
      rsp_pop_ff <= rsp_pop_in;     rsp_front_ff <= rsp_front_in;
      rsp_back_ff <= rsp_back_in;   rsp_cnt_ff <= rsp_cnt_in;
      rsp_empty_ff <= rsp_empty_in; rsp_sts_ff <= rsp_sts_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_pop_ff;
   assign rsp_front_value  = rsp_front_ff;
   assign rsp_back_value   = rsp_back_ff;
   assign rsp_item_count   = rsp_cnt_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_status       = rsp_sts_ff;

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH)) else $error("entry count beyond depth");
   a_resp_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.op == CMD_RESP |=> rsp_valid_ff) else $error("response not raised");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.op == CMD_RESP |-> !(rsp_valid_ff && rsp_stall))
      else $error("pending response overwritten");
   a_empty_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_empty_ff == (rsp_cnt_ff == '0)))
      else $error("empty flag disagrees with count");
`endif

endmodule

// ----- rtl/core/double_ended_queue_engine_unit.sv -----
// Top level of the double-ended queue engine.
// Depends on dqe_pkg, dqe_ctrl, dqe_datapath (which holds dqe_ram).
//
// Request channel req_*: valid/stall. A request (req_type, req_data_value) is
// taken at an edge with req_valid high and req_stall low. Codes: push front,
// push back, pop front, pop back, query, clear, reverse, sort ascending.
// Response channel rsp_*: one response per request, held in an output register
// until the receiver drops rsp_stall; a stalled response does not change.
// The engine works one request at a time and holds req_stall high meanwhile.
// From acceptance to rsp_valid a request passes the states EXEC, RD_FRONT,
// RD_BACK, CAP_BACK and OUT; a pop on a non-empty deque adds POP_WAIT (one
// extra store read). Front and back are re-read from the single-read-port
// store after each step.
// Reverse swaps pairs from both ends inward. Sort is a bubble sort over the
// store, passing over neighbour pairs and running one pass more than needed
// to order the words.
// A new request may be taken while the previous response still waits.
// Reset (synchronous, active high) empties the deque and drops rsp_valid;
// the store itself is not cleared, and a push on a full deque is dropped.
module double_ended_queue_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_data_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_popped_value,
   output logic [31:0] rsp_front_value,
   output logic [31:0] rsp_back_value,
   output logic [10:0] rsp_item_count,
   output logic        rsp_is_empty,
   output logic [1:0]  rsp_status
);
   import dqe_pkg::*;

   ctrl_cmd_type  cmd;     // controller to datapath
   dp_status_type dp_sts;  // datapath conditions back to the controller

   dqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_sts    (dp_sts),
      .cmd       (cmd)
   );

   dqe_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .dp_sts           (dp_sts),
      .req_type         (req_type),
      .req_data_value   (req_data_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_popped_value (rsp_popped_value),
      .rsp_front_value  (rsp_front_value),
      .rsp_back_value   (rsp_back_value),
      .rsp_item_count   (rsp_item_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_status       (rsp_status)
   );

endmodule
